### src/video_config_record_to_annexb_macros.svh
// Assertion macros shared by the record-to-Annex-B converter.
`ifndef VIDEO_CONFIG_RECORD_TO_ANNEXB_MACROS_SVH
`define VIDEO_CONFIG_RECORD_TO_ANNEXB_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define VCR2AB_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define VCR2AB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/vcr2ab_pkg.sv
// Types and constants shared by the record-to-Annex-B converter.
package vcr2ab_pkg;

  // Parser phases.
  localparam logic [3:0] PH_HEAD    = 4'd0;
  localparam logic [3:0] PH_PPSCNT  = 4'd1;
  localparam logic [3:0] PH_ARRTYPE = 4'd2;
  localparam logic [3:0] PH_CNTHI   = 4'd3;
  localparam logic [3:0] PH_CNTLO   = 4'd4;
  localparam logic [3:0] PH_LENHI   = 4'd5;
  localparam logic [3:0] PH_LENLO   = 4'd6;
  localparam logic [3:0] PH_DATA    = 4'd7;
  localparam logic [3:0] PH_BAD     = 4'd8;

  // Record formats.
  localparam logic FMT_AVCC = 1'b0;
  localparam logic FMT_HVCC = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_VER   = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_MISSING   = 2'd3;

  // NAL unit types of the parameter sets.
  localparam logic [5:0] NAL_VPS = 6'd32;
  localparam logic [5:0] NAL_SPS = 6'd33;
  localparam logic [5:0] NAL_PPS = 6'd34;

  // Header layout.
  localparam logic [7:0] RECORD_VERSION = 8'h01;
  localparam logic [4:0] AVCC_SPS_POS   = 5'd5;
  localparam logic [4:0] HVCC_ARR_POS   = 5'd22;

  // Required sets, bit 0 VPS, bit 1 SPS, bit 2 PPS.
  localparam logic [2:0] NEED_AVCC = 3'b110;
  localparam logic [2:0] NEED_HVCC = 3'b111;

  // Results caused by one input byte: an optional four-byte start code or
  // one payload byte, then an optional status.
  typedef struct packed {
    logic       sc;
    logic       dat;
    logic       stat;
    logic [7:0] data_byte;
    logic [1:0] tgt;
    logic [1:0] status;
  } bundle_t;

endpackage

### src/vcr2ab_parse.sv
// Record parser: walks the configuration record and describes each byte's results.
module vcr2ab_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                fmt,
  input  logic [7:0]          in_byte,
  input  logic                fin,
  output vcr2ab_pkg::bundle_t bundle
);

  logic [3:0]  phase, phase_next;
  logic [4:0]  pos, pos_next;
  logic [7:0]  lists, lists_next;
  logic [15:0] units, units_next;
  logic        first, first_next;
  logic [15:0] hold, hold_next;
  logic [15:0] payload, payload_next;
  logic [5:0]  cur_type, cur_type_next;
  logic [2:0]  seen, seen_next;
  logic        closed, closed_next;

  logic        active;
  logic        is_target;
  logic [1:0]  tgt;
  logic        do_start;
  logic        do_end_unit;
  logic [15:0] cnt;
  logic [15:0] len;
  logic [2:0]  need;

  assign is_target = (cur_type >= vcr2ab_pkg::NAL_VPS) && (cur_type <= vcr2ab_pkg::NAL_PPS);
  assign tgt       = cur_type[1:0];
  assign active    = take && !closed && (phase != vcr2ab_pkg::PH_BAD);
  assign len       = hold | {8'd0, in_byte};
  assign need      = (fmt == vcr2ab_pkg::FMT_HVCC) ? vcr2ab_pkg::NEED_HVCC
                                                   : vcr2ab_pkg::NEED_AVCC;

  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    lists_next    = lists;
    units_next    = units;
    first_next    = first;
    hold_next     = hold;
    payload_next  = payload;
    cur_type_next = cur_type;
    seen_next     = seen;
    closed_next   = closed;
    do_start      = 1'b0;
    do_end_unit   = 1'b0;
    cnt           = 16'd0;
    bundle        = '0;

    if (active) begin
      case (phase)
        vcr2ab_pkg::PH_HEAD: begin
          if (pos == 5'd0 && in_byte != vcr2ab_pkg::RECORD_VERSION) begin
            phase_next = vcr2ab_pkg::PH_BAD;
          end else if (fmt == vcr2ab_pkg::FMT_AVCC && pos >= vcr2ab_pkg::AVCC_SPS_POS) begin
            cur_type_next = vcr2ab_pkg::NAL_SPS;
            do_start      = 1'b1;
            cnt           = {11'd0, in_byte[4:0]};
          end else if (fmt == vcr2ab_pkg::FMT_HVCC && pos >= vcr2ab_pkg::HVCC_ARR_POS) begin
            lists_next = in_byte;
            if (in_byte == 8'd0) begin
              closed_next = 1'b1;
            end else begin
              phase_next = vcr2ab_pkg::PH_ARRTYPE;
            end
          end else begin
            pos_next = pos + 5'd1;
          end
        end
        vcr2ab_pkg::PH_PPSCNT: begin
          cur_type_next = vcr2ab_pkg::NAL_PPS;
          do_start      = 1'b1;
          cnt           = {8'd0, in_byte};
        end
        vcr2ab_pkg::PH_ARRTYPE: begin
          cur_type_next = in_byte[5:0];
          phase_next    = vcr2ab_pkg::PH_CNTHI;
        end
        vcr2ab_pkg::PH_CNTHI: begin
          hold_next  = {in_byte, 8'd0};
          phase_next = vcr2ab_pkg::PH_CNTLO;
        end
        vcr2ab_pkg::PH_CNTLO: begin
          do_start = 1'b1;
          cnt      = len;
        end
        vcr2ab_pkg::PH_LENHI: begin
          hold_next  = {in_byte, 8'd0};
          phase_next = vcr2ab_pkg::PH_LENLO;
        end
        vcr2ab_pkg::PH_LENLO: begin
          payload_next = len;
          if (first && is_target) begin
            bundle.sc  = 1'b1;
            bundle.tgt = tgt;
            seen_next  = seen | 3'(3'b001 << tgt);
          end
          if (len == 16'd0) begin
            do_end_unit = 1'b1;
          end else begin
            phase_next = vcr2ab_pkg::PH_DATA;
          end
        end
        vcr2ab_pkg::PH_DATA: begin
          if (first && is_target) begin
            bundle.dat       = 1'b1;
            bundle.data_byte = in_byte;
            bundle.tgt       = tgt;
          end
          if (payload <= 16'd1) begin
            payload_next = 16'd0;
            do_end_unit  = 1'b1;
          end else begin
            payload_next = payload - 16'd1;
          end
        end
        default: begin
        end
      endcase
    end

    // A new list begins with its unit count.
    if (do_start) begin
      units_next = cnt;
      first_next = 1'b1;
      if (cnt == 16'd0) begin
        if (fmt == vcr2ab_pkg::FMT_AVCC) begin
          closed_next = 1'b1;
        end else if (lists <= 8'd1) begin
          lists_next  = 8'd0;
          closed_next = 1'b1;
        end else begin
          lists_next = lists - 8'd1;
          phase_next = vcr2ab_pkg::PH_ARRTYPE;
        end
      end else begin
        phase_next = vcr2ab_pkg::PH_LENHI;
      end
    end

    // A unit is finished; move to the next unit, the next list or the end.
    if (do_end_unit) begin
      first_next = 1'b0;
      if (units <= 16'd1) begin
        units_next = 16'd0;
        if (fmt == vcr2ab_pkg::FMT_AVCC) begin
          if (cur_type == vcr2ab_pkg::NAL_SPS) begin
            phase_next = vcr2ab_pkg::PH_PPSCNT;
          end else begin
            closed_next = 1'b1;
          end
        end else if (lists <= 8'd1) begin
          lists_next  = 8'd0;
          closed_next = 1'b1;
        end else begin
          lists_next = lists - 8'd1;
          phase_next = vcr2ab_pkg::PH_ARRTYPE;
        end
      end else begin
        units_next = units - 16'd1;
        phase_next = vcr2ab_pkg::PH_LENHI;
      end
    end

    // The last byte reports the outcome and rearms the parser.
    if (take && fin) begin
      bundle.stat = 1'b1;
      if (phase_next == vcr2ab_pkg::PH_BAD) begin
        bundle.status = vcr2ab_pkg::ST_BAD_VER;
      end else if (closed_next) begin
        bundle.status = ((seen_next & need) == need) ? vcr2ab_pkg::ST_OK
                                                     : vcr2ab_pkg::ST_MISSING;
      end else begin
        bundle.status = vcr2ab_pkg::ST_TRUNCATED;
      end
      phase_next    = vcr2ab_pkg::PH_HEAD;
      pos_next      = 5'd0;
      lists_next    = 8'd0;
      units_next    = 16'd0;
      first_next    = 1'b1;
      hold_next     = 16'd0;
      payload_next  = 16'd0;
      cur_type_next = 6'd0;
      seen_next     = 3'd0;
      closed_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= vcr2ab_pkg::PH_HEAD;
      pos      <= 5'd0;
      lists    <= 8'd0;
      units    <= 16'd0;
      first    <= 1'b1;
      hold     <= 16'd0;
      payload  <= 16'd0;
      cur_type <= 6'd0;
      seen     <= 3'd0;
      closed   <= 1'b0;
    end else if (take) begin
      phase    <= phase_next;
      pos      <= pos_next;
      lists    <= lists_next;
      units    <= units_next;
      first    <= first_next;
      hold     <= hold_next;
      payload  <= payload_next;
      cur_type <= cur_type_next;
      seen     <= seen_next;
      closed   <= closed_next;
    end
  end

endmodule

### src/video_config_record_to_annexb.sv
// Top level of the avcC/hvcC configuration record to Annex-B converter.
//
// The record arrives on the slave stream one byte per request, with tlast
// on its last byte. The cfg channel writes the format register (0 avcC,
// 1 hvcC); it is always ready and should only be written while idle.
// Each accepted byte is parsed in the cycle it arrives and the results it
// causes (none, one payload byte, a four-byte start code, plus a status on
// the last byte) are captured in one result register, from which the
// master stream sends them one per cycle while m_tready is high, tlast
// marking the last result of a byte. The first result of a byte is
// offered in the cycle after the byte is taken. A byte causing zero or
// one result sustains one byte per cycle while the receiver is ready; a
// byte with more results holds further input until they have drained.
// A new byte is taken in the same cycle the last pending result
// leaves, so a stalled receiver holds the input back without loss.
// Reset clears the parser to the header phase, empties the result
// register and sets the format to avcC.
module video_config_record_to_annexb (
  input  logic        clk,
  input  logic        rst,
  // Slave stream: tdata[7:0] record_byte; tlast final_byte.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  // Master stream: tdata[7:0] out_byte, [9:8] status_code, upper bits zero.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  // tuser[1:0] target_set, [2] is_data, [3] is_status.
  output logic [3:0]  m_tuser,
  output logic        m_tlast,
  // Configuration: cfg_data[0] record_format.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  `include "video_config_record_to_annexb_macros.svh"

  logic                fmt;
  logic                s_acc;
  logic                m_acc;
  vcr2ab_pkg::bundle_t new_bnd;
  vcr2ab_pkg::bundle_t bnd;
  logic                bvalid;
  logic [2:0]          idx;
  logic [2:0]          count;
  logic                last;
  logic                in_sc;
  logic                in_dat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= vcr2ab_pkg::FMT_AVCC;
    end else if (cfg_valid && cfg_ready) begin
      fmt <= cfg_data;
    end
  end

  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;

  vcr2ab_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .take    (s_acc),
    .fmt     (fmt),
    .in_byte (s_tdata),
    .fin     (s_tlast),
    .bundle  (new_bnd)
  );

  // Number of results held and whether the one on the bus is the last.
  assign count = (bnd.sc ? 3'd4 : 3'd0) + {2'd0, bnd.dat} + {2'd0, bnd.stat};
  assign last  = (idx == count - 3'd1);

  // Input is taken when the result register is empty or its last result
  // is leaving in this cycle.
  assign s_tready = !bvalid || (m_tready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      idx    <= 3'd0;
    end else if (s_acc) begin
      bvalid <= new_bnd.sc || new_bnd.dat || new_bnd.stat;
      idx    <= 3'd0;
    end else if (m_acc) begin
      if (last) begin
        bvalid <= 1'b0;
        idx    <= 3'd0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      bnd <= new_bnd;
    end
  end

  // Start code bytes come first, then the payload byte, then the status.
  assign in_sc  = bnd.sc && (idx < 3'd4);
  assign in_dat = bnd.dat && (idx == 3'd0);

  always_comb begin
    m_tvalid = bvalid;
    m_tlast  = last;
    m_tdata  = 16'd0;
    m_tuser  = 4'd0;
    if (in_sc) begin
      m_tdata[7:0] = (idx == 3'd3) ? 8'h01 : 8'h00;
      m_tuser[1:0] = bnd.tgt;
      m_tuser[2]   = 1'b1;
    end else if (in_dat) begin
      m_tdata[7:0] = bnd.data_byte;
      m_tuser[1:0] = bnd.tgt;
      m_tuser[2]   = 1'b1;
    end else begin
      m_tdata[9:8] = bnd.status;
      m_tuser[3]   = 1'b1;
    end
  end

  // A status result always closes the results of its byte.
  `VCR2AB_ASSERT(a_status_last, m_tvalid && m_tuser[3], m_tlast, "status not last result")
  // Input is only taken over a full result register when it is draining.
  `VCR2AB_ASSERT(a_ready_drain, bvalid && s_tready, m_tready && last, "input taken while busy")
  // The last record byte always leaves a status pending.
  `VCR2AB_ASSERT_NEXT(a_final_status, s_acc && s_tlast, bvalid && bnd.stat, "status lost")
  // The result pointer stays within the results held.
  `VCR2AB_ASSERT(a_idx_range, bvalid, idx < count, "result pointer out of range")

endmodule
